// ===== src/bce_pkg.sv =====
`timescale 1ns / 1ps

package bce_pkg;

    localparam int DATA_W   = 8;
    localparam int CRC_W    = 24;
    localparam int CHAN_W   = 6;
    localparam int WHITEN_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0]     CRC_POLY       = 24'h00065B;
    localparam logic [CRC_W-1:0]     CRC_SEED_RESET = 24'h555555;
    localparam logic [CHAN_W-1:0]    CHANNEL_RESET  = 6'd37;

    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL  = 2'd1;

    // Output phases of one queued word: the data byte, then three CRC bytes if it is the last word of a packet.
    localparam logic [1:0] PH_DATA = 2'd0;
    localparam logic [1:0] PH_CRC2 = 2'd1;
    localparam logic [1:0] PH_CRC1 = 2'd2;
    localparam logic [1:0] PH_CRC0 = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] pdu_byte;
        logic              last;
        logic [CRC_W-1:0]  crc;
    } t_entry;

    function automatic logic [DATA_W-1:0] rev8(input logic [DATA_W-1:0] a);
        logic [DATA_W-1:0] r;
        for (int k = 0; k < DATA_W; k++) begin
            r[k] = a[DATA_W-1-k];
        end
        return r;
    endfunction

    // Eight CRC steps, data taken LSB first.
    function automatic logic [CRC_W-1:0] crc8(input logic [CRC_W-1:0] c_in,
                                              input logic [DATA_W-1:0] d);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = c_in;
        for (int k = 0; k < DATA_W; k++) begin
            fb = c[CRC_W-1] ^ d[k];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // The 7-bit state holds bits 7..1 of the classic 8-bit whitening register.
    function automatic logic [WHITEN_W-1:0] whiten_seed(input logic [CHAN_W-1:0] ch);
        logic [WHITEN_W-1:0] s;
        for (int k = 0; k < CHAN_W; k++) begin
            s[WHITEN_W-1-k] = ch[k];
        end
        s[0] = 1'b1;
        return s;
    endfunction

    // Returns {next state, whitened byte}; data is whitened LSB first.
    function automatic logic [WHITEN_W+DATA_W-1:0] whiten8(input logic [WHITEN_W-1:0] s_in,
                                                          input logic [DATA_W-1:0] b_in);
        logic [WHITEN_W-1:0] s;
        logic [DATA_W-1:0]   b;
        logic                fb;
        s = s_in;
        b = b_in;
        for (int k = 0; k < DATA_W; k++) begin
            fb   = s[WHITEN_W-1];
            b[k] = b[k] ^ fb;
            s    = {s[WHITEN_W-2:0], fb};
            s[4] = s[4] ^ fb;
        end
        return {s, b};
    endfunction

endpackage

// ===== src/bce_ifs.sv =====
`timescale 1ns / 1ps

interface bce_in_if import bce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] pdu_byte;
    logic              last_of_pdu;

    modport source (output valid, output pdu_byte, output last_of_pdu, input ready);
    modport sink   (input valid, input pdu_byte, input last_of_pdu, output ready);
endinterface

interface bce_out_if import bce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] coded_byte;
    logic              is_crc_byte;
    logic              end_of_packet;

    modport source (output valid, output coded_byte, output is_crc_byte,
                    output end_of_packet, input ready);
    modport sink   (input valid, input coded_byte, input is_crc_byte,
                    input end_of_packet, output ready);
endinterface

interface bce_cfg_if import bce_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CRC_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/bce_front.sv =====
`timescale 1ns / 1ps

module bce_front import bce_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bce_in_if.sink           i_in,
    input  logic [CRC_W-1:0] i_crc_seed,
    input  logic             i_full,
    output logic             o_push,
    output t_entry           o_entry
);

    logic             r_open;
    logic             n_open;
    logic [CRC_W-1:0] r_crc;
    logic [CRC_W-1:0] n_crc;
    logic [CRC_W-1:0] crc_base;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // A word that opens a packet starts from the seed register.
    assign crc_base = r_open ? r_crc : i_crc_seed;

    always_comb begin
        n_crc  = r_crc;
        n_open = r_open;
        if (o_push) begin
            n_crc  = crc8(crc_base, i_in.pdu_byte);
            n_open = !i_in.last_of_pdu;
        end
    end

    assign o_entry.pdu_byte = i_in.pdu_byte;
    assign o_entry.last     = i_in.last_of_pdu;
    assign o_entry.crc      = crc8(crc_base, i_in.pdu_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else begin
            r_open <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

endmodule

// ===== src/bce_queue.sv =====
`timescale 1ns / 1ps

module bce_queue import bce_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== src/bce_back.sv =====
`timescale 1ns / 1ps

module bce_back import bce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_entry            i_entry,
    input  logic [CHAN_W-1:0] i_channel,
    output logic              o_pop,
    bce_out_if.source         o_out
);

    logic [1:0]               r_phase;
    logic [1:0]               n_phase;
    logic                     r_open;
    logic                     n_open;
    logic [WHITEN_W-1:0]      r_wstate;
    logic [WHITEN_W-1:0]      w_base;
    logic [DATA_W-1:0]        raw_byte;
    logic [WHITEN_W+DATA_W-1:0] w_res;
    logic                     fire;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_coded;
    logic                     r_crc_flag;
    logic                     r_eop;

    assign fire = i_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        unique case (r_phase)
            PH_DATA: raw_byte = i_entry.pdu_byte;
            PH_CRC2: raw_byte = rev8(i_entry.crc[23:16]);
            PH_CRC1: raw_byte = rev8(i_entry.crc[15:8]);
            PH_CRC0: raw_byte = rev8(i_entry.crc[7:0]);
            default: raw_byte = i_entry.pdu_byte;
        endcase
    end

    // The whitening register is reseeded on the first word of a packet.
    assign w_base = r_open ? r_wstate : whiten_seed(i_channel);
    assign w_res  = whiten8(w_base, raw_byte);

    always_comb begin
        n_phase = r_phase;
        n_open  = r_open;
        o_pop   = 1'b0;
        if (fire) begin
            n_open = 1'b1;
            if (r_phase == PH_DATA) begin
                if (i_entry.last) begin
                    n_phase = PH_CRC2;
                end else begin
                    o_pop = 1'b1;
                end
            end else if (r_phase == PH_CRC0) begin
                n_phase = PH_DATA;
                n_open  = 1'b0;
                o_pop   = 1'b1;
            end else begin
                n_phase = r_phase + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DATA;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_open  <= n_open;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_wstate   <= w_res[WHITEN_W+DATA_W-1:DATA_W];
            r_coded    <= rev8(w_res[DATA_W-1:0]);
            r_crc_flag <= (r_phase != PH_DATA);
            r_eop      <= (r_phase == PH_CRC0);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.coded_byte    = r_coded;
    assign o_out.is_crc_byte   = r_crc_flag;
    assign o_out.end_of_packet = r_eop;

    // While CRC bytes go out, the word that carries them stays at the queue head.
    a_crc_phase_holds_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DATA) |-> (i_valid && i_entry.last))
        else $error("CRC phase without a last word at the queue head");

    a_eop_closes_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_phase == PH_CRC0) |=> (!r_open && r_phase == PH_DATA))
        else $error("packet not closed after the final CRC byte");

    a_no_pop_mid_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_phase != PH_DATA) |-> (r_phase == PH_CRC0))
        else $error("word popped before its CRC bytes were sent");

    a_eop_is_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_eop) |-> r_crc_flag)
        else $error("end of packet flagged on a data byte");

endmodule

// ===== src/ble_crc24_whiten_encoder.sv =====
`timescale 1ns / 1ps

// BLE link-layer encoder: CRC-24 and whitening for an MSB-first radio.
// i_in carries PDU bytes, one word per handshake; last_of_pdu marks the final
// byte of a packet. o_out carries coded bytes: every PDU byte whitened and
// bit-reversed, and after the last one three CRC bytes, high byte first,
// with is_crc_byte set and end_of_packet set on the third.
// i_cfg writes crc_seed (index 0) and channel_index (index 1); it is always
// ready. Writes must be made while the block is idle, which the block itself
// does not enforce; they take effect when the next packet starts.
// An accepted input word passes through the queue and the output register
// before its coded byte appears on o_out. Throughput is one byte per cycle
// while o_out.ready is high; the last byte of a packet holds the output side
// for its data byte and three CRC bytes, set by the single whitening unit in
// the back end. A two-word queue between the CRC front end and the whitening
// back end absorbs that, so input is only stalled when the queue fills.
// Reset clears the queue, the output register and the packet state and loads
// the registers with seed 0x555555 and channel 37. When the receiver stalls,
// o_out holds its word, the queue fills and then i_in.ready drops.
module ble_crc24_whiten_encoder import bce_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bce_in_if.sink   i_in,
    bce_cfg_if.sink  i_cfg,
    bce_out_if.source o_out
);

    logic [CRC_W-1:0]  r_crc_seed;
    logic [CHAN_W-1:0] r_channel;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    t_entry            q_wr_entry;
    t_entry            q_rd_entry;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_seed <= CRC_SEED_RESET;
            r_channel  <= CHANNEL_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_CRC_SEED) begin
                r_crc_seed <= i_cfg.data;
            end else if (i_cfg.index == CFG_CHANNEL) begin
                r_channel <= i_cfg.data[CHAN_W-1:0];
            end
        end
    end

    bce_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_crc_seed (r_crc_seed),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_entry    (q_wr_entry)
    );

    bce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_rd_entry)
    );

    bce_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_entry   (q_rd_entry),
        .i_channel (r_channel),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb import bce_pkg::*; ();

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 330;

    logic i_clk;
    logic i_rst_n;

    bce_in_if  in_if ();
    bce_out_if out_if ();
    bce_cfg_if cfg_if ();

    ble_crc24_whiten_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Tracks the encoder state and holds the coded bytes still owed by the block.
    class coded_byte_board;
        typedef struct {
            logic [DATA_W-1:0] coded;
            logic              is_crc;
            logic              eop;
        } coded_word_t;

        coded_word_t       owed_q[$];
        logic [CRC_W-1:0]  seed_reg;
        logic [CHAN_W-1:0] chan_reg;
        logic [CRC_W-1:0]  crc_acc;
        // Full 8-bit whitening register; bit 0 is always zero between bytes.
        logic [7:0]        white_acc;
        bit                open;
        int                errors;
        int                checked;
        int                bytes_in;
        int                packets;
        int                writes;

        function new();
            seed_reg  = CRC_SEED_RESET;
            chan_reg  = CHANNEL_RESET;
            crc_acc   = seed_reg;
            white_acc = lfsr_load(chan_reg);
            open      = 1'b0;
        endfunction

        function logic [7:0] flip(input logic [7:0] a);
            logic [7:0] r;
            for (int k = 0; k < 8; k++) begin
                r[k] = a[7-k];
            end
            return r;
        endfunction

        function logic [7:0] lfsr_load(input logic [CHAN_W-1:0] ch);
            return flip({2'b00, ch}) | 8'h02;
        endfunction

        function logic [7:0] whiten(input logic [7:0] b);
            logic [7:0] w;
            w = b;
            for (int k = 0; k < 8; k++) begin
                if (white_acc[7]) begin
                    white_acc = white_acc ^ 8'h11;
                    w[k] = ~w[k];
                end
                white_acc = white_acc << 1;
            end
            return w;
        endfunction

        function void feed_crc(input logic [7:0] d);
            logic top;
            for (int k = 0; k < 8; k++) begin
                top = crc_acc[CRC_W-1];
                crc_acc = crc_acc << 1;
                if (top != d[k]) begin
                    crc_acc = crc_acc ^ CRC_POLY;
                end
            end
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] data);
            writes++;
            case (idx)
                CFG_CRC_SEED: seed_reg = data;
                CFG_CHANNEL:  chan_reg = data[CHAN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_pdu_byte(input logic [DATA_W-1:0] b, input logic last);
            coded_word_t w;
            logic [7:0]  cb;
            bytes_in++;
            // Register writes only take hold when a new packet opens.
            if (!open) begin
                crc_acc   = seed_reg;
                white_acc = lfsr_load(chan_reg);
                open      = 1'b1;
            end
            feed_crc(b);
            w.coded  = flip(whiten(b));
            w.is_crc = 1'b0;
            w.eop    = 1'b0;
            owed_q.push_back(w);
            if (last) begin
                for (int k = 0; k < 3; k++) begin
                    cb       = crc_acc[CRC_W-1-8*k -: 8];
                    w.coded  = flip(whiten(flip(cb)));
                    w.is_crc = 1'b1;
                    w.eop    = (k == 2);
                    owed_q.push_back(w);
                end
                open = 1'b0;
                packets++;
            end
        endfunction

        function void check_coded_byte(input logic [DATA_W-1:0] coded, input logic is_crc,
                                       input logic eop);
            coded_word_t w;
            checked++;
            if (owed_q.size() == 0) begin
                $error("unexpected word: coded_byte %h is_crc_byte %b end_of_packet %b",
                       coded, is_crc, eop);
                errors++;
            end else begin
                w = owed_q.pop_front();
                if (coded !== w.coded) begin
                    $error("coded_byte expected %h actual %h", w.coded, coded);
                    errors++;
                end
                if (is_crc !== w.is_crc) begin
                    $error("is_crc_byte expected %b actual %b", w.is_crc, is_crc);
                    errors++;
                end
                if (eop !== w.eop) begin
                    $error("end_of_packet expected %b actual %b", w.eop, eop);
                    errors++;
                end
            end
        endfunction
    endclass

    coded_byte_board board;
    int  cycles;
    int  idle_mode;
    bit  in_held;
    int  sent;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                board.write_reg(cfg_if.index, cfg_if.data);
            end
            if (out_if.valid && out_if.ready) begin
                board.check_coded_byte(out_if.coded_byte, out_if.is_crc_byte,
                                       out_if.end_of_packet);
            end
            if (in_if.valid && in_if.ready) begin
                board.note_pdu_byte(in_if.pdu_byte, in_if.last_of_pdu);
            end
        end
    end

    // Mode 0 never idles, mode 1 idles now and then, mode 2 idles on most words.
    function automatic int draw_wait();
        case (idle_mode)
            0: return 0;
            1: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 18) : 0;
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    // Receiver side: stalls a random number of cycles before each word.
    initial begin
        int stall;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    task automatic drop_in_valid();
        if (in_held) begin
            in_if.valid <= 1'b0;
            in_held = 1'b0;
        end
    endtask

    task automatic push_byte(input logic [DATA_W-1:0] b, input logic last);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            drop_in_valid();
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.pdu_byte    <= b;
        in_if.last_of_pdu <= last;
        in_held = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        sent++;
    endtask

    task automatic send_packet(input int len, input bit close);
        for (int i = 0; i < len; i++) begin
            push_byte(8'($urandom), close && (i == len - 1));
        end
    endtask

    // Sampling on the falling edge keeps the check clear of the monitor's update.
    task automatic wait_drained();
        drop_in_valid();
        do @(negedge i_clk); while (board.pending() != 0);
        @(posedge i_clk);
    endtask

    task automatic set_config(input bit do_seed, input logic [CRC_W-1:0] seed,
                              input bit do_chan, input logic [CHAN_W-1:0] chan);
        if (do_seed) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= CFG_CRC_SEED;
            cfg_if.data  <= seed;
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        if (do_chan) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= CFG_CHANNEL;
            cfg_if.data  <= {{(CRC_W-CHAN_W){1'b0}}, chan};
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        if (do_seed || do_chan) begin
            cfg_if.valid <= 1'b0;
        end
    endtask

    function automatic logic [CRC_W-1:0] pick_seed();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return CRC_SEED_RESET;
            default: return CRC_W'($urandom);
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] pick_channel();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 6'd39;
            2: return '1;
            3: return CHAN_W'($urandom_range(40, 63));
            default: return CHAN_W'($urandom_range(0, 39));
        endcase
    endfunction

    initial begin
        int phases;
        int len;
        bit do_seed;
        bit do_chan;

        board = new();
        sent = 0;
        phases = 0;
        in_held = 1'b0;
        idle_mode = 1;
        in_if.valid       <= 1'b0;
        in_if.pdu_byte    <= '0;
        in_if.last_of_pdu <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= CFG_CRC_SEED;
        cfg_if.data       <= '0;
        i_rst_n           <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, a one-byte packet, then a short one.
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hA5, 1'b1);
        wait_drained();
        set_config(1'b1, 24'hFFFFFF, 1'b1, 6'd0);
        push_byte(8'hFF, 1'b1);
        wait_drained();
        set_config(1'b1, 24'h000000, 1'b1, 6'd39);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b1);
        wait_drained();
        set_config(1'b1, CRC_SEED_RESET, 1'b1, 6'd63);
        push_byte(8'h01, 1'b0);
        push_byte(8'hFE, 1'b1);
        // New settings written while a packet is open must wait for the next packet.
        push_byte(8'h3C, 1'b0);
        push_byte(8'hC3, 1'b0);
        wait_drained();
        set_config(1'b1, 24'h123456, 1'b1, 6'd12);
        push_byte(8'h7E, 1'b1);
        push_byte(8'h5A, 1'b1);
        wait_drained();
        set_config(1'b0, '0, 1'b1, 6'd40);
        push_byte(8'h81, 1'b1);

        while (sent < RANDOM_ITEMS) begin
            // Each phase ends with the pipe empty, though a packet may still be open.
            wait_drained();
            do_seed = $urandom_range(0, 1);
            do_chan = $urandom_range(0, 1);
            set_config(do_seed, pick_seed(), do_chan, pick_channel());
            idle_mode = $urandom_range(0, 2);
            phases++;
            repeat ($urandom_range(1, 5)) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                send_packet(len, 1'b1);
            end
            if ($urandom_range(0, 4) == 0) begin
                send_packet($urandom_range(1, 4), 1'b0);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Encoded %0d PDU bytes in %0d closed packets over %0d random phases.",
                 board.bytes_in, board.packets, phases);
        $display("Checked %0d coded bytes after %0d register writes.",
                 board.checked, board.writes);
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
